[rtl/core/orts_pkg.sv]
// ----------------------------------------------------------------------------
// orts_pkg
// Shared widths, codes, types and helpers of the overwrite ring trace store.
// ----------------------------------------------------------------------------
`default_nettype none

package orts_pkg;

    localparam int FUNC_W        = 2;
    localparam int SEV_W         = 3;
    localparam int CID_W         = 32;
    localparam int IDX_W         = 7;
    localparam int CNT_W         = 48;
    localparam int LEVELS        = 5;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [IDX_W-1:0] CAP_RESET = IDX_W'(64);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // Operation codes; the fourth code has no meaning and changes nothing.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    typedef enum logic {
        STATUS_OK        = 1'b0,
        STATUS_NOT_FOUND = 1'b1
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SEV_W-1:0]  severity;
        logic [CID_W-1:0]  trace_tag;
        logic [IDX_W-1:0]  read_index;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] seq;
        logic [SEV_W-1:0] sev;
        logic [CID_W-1:0] cid;
    } entry_t;

    typedef struct packed {
        logic                         status;
        logic [CNT_W-1:0]             rd_sequence;
        logic [SEV_W-1:0]             rd_severity;
        logic [CID_W-1:0]             rd_trace_tag;
        logic [IDX_W-1:0]             retained_now;
        logic [CNT_W-1:0]             received_total;
        logic [CNT_W-1:0]             overwritten_total;
        logic [LEVELS-1:0][IDX_W-1:0] level_count;
    } rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/core/orts_req_if.sv]
// ----------------------------------------------------------------------------
// orts_req_if
// Request channel: one operation beat with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface orts_req_if import orts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SEV_W-1:0]  severity;
    logic [CID_W-1:0]  trace_tag;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, func, severity, trace_tag, read_index,
                    input ready);
    modport sink   (input valid, func, severity, trace_tag, read_index,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/orts_rsp_if.sv]
// ----------------------------------------------------------------------------
// orts_rsp_if
// Result channel: one result beat per operation with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface orts_rsp_if import orts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic [CNT_W-1:0] rd_sequence;
    logic [SEV_W-1:0] rd_severity;
    logic [CID_W-1:0] rd_trace_tag;
    logic [IDX_W-1:0] retained_now;
    logic [CNT_W-1:0] received_total;
    logic [CNT_W-1:0] overwritten_total;
    logic [IDX_W-1:0] trace_retained;
    logic [IDX_W-1:0] info_retained;
    logic [IDX_W-1:0] warning_retained;
    logic [IDX_W-1:0] error_retained;
    logic [IDX_W-1:0] fatal_retained;

    modport source (output valid, status, rd_sequence, rd_severity, rd_trace_tag,
                    retained_now, received_total, overwritten_total, trace_retained,
                    info_retained, warning_retained, error_retained, fatal_retained,
                    input ready);
    modport sink   (input valid, status, rd_sequence, rd_severity, rd_trace_tag,
                    retained_now, received_total, overwritten_total, trace_retained,
                    info_retained, warning_retained, error_retained, fatal_retained,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/orts_cfg_if.sv]
// ----------------------------------------------------------------------------
// orts_cfg_if
// Configuration write channel carrying the capacity register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface orts_cfg_if import orts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] capacity_in_use;

    modport source (output valid, capacity_in_use, input ready);
    modport sink   (input valid, capacity_in_use, output ready);
endinterface

`default_nettype wire

[rtl/core/orts_ring_mem.sv]
// ----------------------------------------------------------------------------
// orts_ring_mem
// Entry memory: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module orts_ring_mem import orts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];
    entry_t mem_rd_reg;
    entry_t byp_data_reg;
    logic   byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            mem_rd_reg   <= mem[raddr];
            byp_data_reg <= wdata;
        end
    end

    // A read that lands on the slot written in the same cycle sees the new entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (re)
        begin
            byp_hit_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = byp_hit_reg ? byp_data_reg : mem_rd_reg;

endmodule

`default_nettype wire

[rtl/core/orts_engine.sv]
// ----------------------------------------------------------------------------
// orts_engine
// Ring pointers, counters and the per-operation update and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module orts_engine import orts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cap_reg,
    input  wire logic             commit,
    input  wire req_t             item,
    input  wire entry_t           rdata,
    input  wire req_t             nxt_item,
    output logic [AW-1:0]         raddr,
    output logic                  we,
    output logic [AW-1:0]         waddr,
    output entry_t                wdata,
    output rsp_t                  result
);

    localparam int SUM_W = IDX_W + 1;

    logic [AW-1:0]                oldest_reg, oldest_next;
    logic [IDX_W-1:0]             held_reg, held_next;
    logic [CNT_W-1:0]             appended_reg, appended_next;
    logic [CNT_W-1:0]             lost_reg, lost_next;
    logic [LEVELS-1:0][IDX_W-1:0] lvl_reg, lvl_next;

    logic [IDX_W-1:0] cap_eff;
    logic [SUM_W-1:0] cap_w, oldest_w, tail_sum, old_inc, rd_sum, nxt_sum;
    logic [AW-1:0]    tail_slot, oldest_wrap;
    logic             full;
    logic [CNT_W-1:0] appended_inc;
    logic             not_found;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = IDX_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            cap_eff = IDX_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign cap_w    = SUM_W'(cap_eff);
    assign oldest_w = SUM_W'(oldest_reg);
    assign full     = held_reg >= cap_eff;
    assign tail_sum = oldest_w + SUM_W'(held_reg);
    assign old_inc  = oldest_w + SUM_W'(1);
    assign tail_slot   = AW'((tail_sum >= cap_w) ? tail_sum - cap_w : tail_sum);
    assign oldest_wrap = (old_inc >= cap_w) ? '0 : AW'(old_inc);
    assign appended_inc = sat_inc(appended_reg);
    assign not_found = item.read_index >= held_reg;

    // State update of the operation that leaves the input register this cycle.
    always_comb
    begin
        oldest_next   = oldest_reg;
        held_next     = held_reg;
        appended_next = appended_reg;
        lost_next     = lost_reg;
        lvl_next      = lvl_reg;
        we            = 1'b0;
        waddr         = tail_slot;
        wdata.seq     = appended_inc;
        wdata.sev     = item.severity;
        wdata.cid     = item.trace_tag;
        if (commit)
        begin
            unique case (func_t'(item.func))
                FUNC_APPEND:
                begin
                    we            = 1'b1;
                    appended_next = appended_inc;
                    if (full)
                    begin
                        waddr       = oldest_reg;
                        oldest_next = oldest_wrap;
                        lost_next   = sat_inc(lost_reg);
                    end
                    else
                    begin
                        held_next = held_reg + IDX_W'(1);
                    end
                    for (int k = 0; k < LEVELS; k++)
                    begin
                        lvl_next[k] = lvl_reg[k]
                            - IDX_W'(full && (int'(rdata.sev) == k) && (lvl_reg[k] != '0))
                            + IDX_W'(int'(item.severity) == k);
                    end
                end
                FUNC_CLEAR:
                begin
                    oldest_next   = '0;
                    held_next     = '0;
                    appended_next = '0;
                    lost_next     = '0;
                    lvl_next      = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read address of the next operation, taken from the state it will see.
    assign nxt_sum = SUM_W'(oldest_next) + SUM_W'(nxt_item.read_index);
    assign rd_sum  = (nxt_sum >= cap_w) ? nxt_sum - cap_w : nxt_sum;
    assign raddr   = (func_t'(nxt_item.func) == FUNC_READ) ? AW'(rd_sum) : oldest_next;

    always_comb
    begin
        result.status            = STATUS_OK;
        result.rd_sequence       = '0;
        result.rd_severity       = '0;
        result.rd_trace_tag      = '0;
        if (func_t'(item.func) == FUNC_READ)
        begin
            if (not_found)
            begin
                result.status = STATUS_NOT_FOUND;
            end
            else
            begin
                result.rd_sequence  = rdata.seq;
                result.rd_severity  = rdata.sev;
                result.rd_trace_tag = rdata.cid;
            end
        end
        result.retained_now      = held_next;
        result.received_total    = appended_next;
        result.overwritten_total = lost_next;
        result.level_count       = lvl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg   <= '0;
            held_reg     <= '0;
            appended_reg <= '0;
            lost_reg     <= '0;
            lvl_reg      <= '0;
        end
        else
        begin
            oldest_reg   <= oldest_next;
            held_reg     <= held_next;
            appended_reg <= appended_next;
            lost_reg     <= lost_next;
            lvl_reg      <= lvl_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/overwrite_ring_trace_store.sv]
// ----------------------------------------------------------------------------
// overwrite_ring_trace_store
// Trace ring buffer that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// The req channel takes one operation per beat: append an entry, read the
// entry at a chronological index (0 is the oldest retained entry), or clear
// the store. Every request beat produces exactly one beat on the rsp channel,
// carrying the read data (zero unless a read finds its entry), a not-found
// status and all retained, received, overwritten and per-severity counts.
// The cfg channel writes the capacity in use; it is always ready and must
// only be written while no operation is in flight. Change it only together
// with a clear.
// The request is registered in the input register and its result in the
// output register, which presents the result beat. Throughput is one
// operation per cycle while rsp takes its results: the entry memory is read
// as the request is registered, and the update of the previous operation is
// forwarded into that read, so back-to-back appends and reads never wait.
// A stalled rsp channel holds its result in the output register; one more
// request may sit in the input register, after which req.ready drops.
// Reset empties the ring, zeroes all counters and sets the capacity to 64.
// Entry contents are not cleared; only written slots are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_trace_store import orts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    orts_req_if.sink   req,
    orts_rsp_if.source rsp,
    orts_cfg_if.sink   cfg
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [IDX_W-1:0] cap_reg;
    logic             s1_valid_reg;
    req_t             s1_item_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;

    logic             s1_go;
    logic             accept;
    req_t             in_item;
    entry_t           rdata;
    entry_t           wdata;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    rsp_t             result;

    // The input stage moves on whenever the output register is free or drains.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_go;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign in_item.func       = req.func;
    assign in_item.severity   = req.severity;
    assign in_item.trace_tag  = req.trace_tag;
    assign in_item.read_index = req.read_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.capacity_in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers load with their stage and need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_go)
        begin
            out_reg <= result;
        end
    end

    orts_ring_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata)
    );

    orts_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cap_reg  (cap_reg),
        .commit   (s1_go),
        .item     (s1_item_reg),
        .rdata    (rdata),
        .nxt_item (in_item),
        .raddr    (raddr),
        .we       (we),
        .waddr    (waddr),
        .wdata    (wdata),
        .result   (result)
    );

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_reg.status;
    assign rsp.rd_sequence       = out_reg.rd_sequence;
    assign rsp.rd_severity       = out_reg.rd_severity;
    assign rsp.rd_trace_tag      = out_reg.rd_trace_tag;
    assign rsp.retained_now      = out_reg.retained_now;
    assign rsp.received_total    = out_reg.received_total;
    assign rsp.overwritten_total = out_reg.overwritten_total;
    assign rsp.trace_retained    = out_reg.level_count[0];
    assign rsp.info_retained     = out_reg.level_count[1];
    assign rsp.warning_retained  = out_reg.level_count[2];
    assign rsp.error_retained    = out_reg.level_count[3];
    assign rsp.fatal_retained    = out_reg.level_count[4];

endmodule

`default_nettype wire
